FILE: design/sts_pkg.sv
// shared types and constants for the sphere triangle subdivider
// no dependencies; every other file refers to it by scoped names
`default_nettype none

package sts_pkg;

    localparam int COORD_W    = 16;
    localparam int SUM_W      = COORD_W + 1;
    localparam int RAD_W      = 15;
    localparam int NORM_W     = 34;
    localparam int SQ_W       = 2 * SUM_W - 1;
    localparam int L2_W       = SQ_W + 1;
    localparam int GUARD_W    = 12;
    localparam int RADICAND_W = L2_W + 2 * GUARD_W;
    localparam int ROOT_W     = (RADICAND_W + 1) / 2;
    localparam int PROD_W     = SUM_W + RAD_W;
    localparam int DIVD_W     = PROD_W + GUARD_W + 1;
    localparam int QUO_W      = COORD_W + 1;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int CROSS_W    = 2 * DIFF_W;
    localparam int QDEPTH     = 2;

    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(4096);
    localparam logic [QUO_W-1:0] POS_LIMIT    = QUO_W'(2 ** (COORD_W - 1) - 1);
    localparam logic [QUO_W-1:0] NEG_LIMIT    = QUO_W'(2 ** (COORD_W - 1));

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [NORM_W-1:0]  norm_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef struct packed {
        norm_t x;
        norm_t y;
        norm_t z;
    } nvec_t;

    typedef struct packed {
        vec_t v0;
        vec_t v1;
        vec_t v2;
        vec_t m01;
        vec_t m12;
        vec_t m20;
    } job_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};
    localparam norm_t  NORM_MAX  = {1'b0, {(NORM_W - 1){1'b1}}};
    localparam norm_t  NORM_MIN  = {1'b1, {(NORM_W - 1){1'b0}}};

endpackage

`default_nettype wire

FILE: design/sts_intf.sv
// valid/ready channel interfaces: triangle input and vertex output
// depends on sts_pkg for field widths
`default_nettype none

interface sts_tri_if;
    logic valid;
    logic ready;
    logic signed [sts_pkg::COORD_W-1:0] a_x;
    logic signed [sts_pkg::COORD_W-1:0] a_y;
    logic signed [sts_pkg::COORD_W-1:0] a_z;
    logic signed [sts_pkg::COORD_W-1:0] b_x;
    logic signed [sts_pkg::COORD_W-1:0] b_y;
    logic signed [sts_pkg::COORD_W-1:0] b_z;
    logic signed [sts_pkg::COORD_W-1:0] c_x;
    logic signed [sts_pkg::COORD_W-1:0] c_y;
    logic signed [sts_pkg::COORD_W-1:0] c_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface

interface sts_vtx_if;
    logic valid;
    logic ready;
    logic signed [sts_pkg::COORD_W-1:0] pos_x;
    logic signed [sts_pkg::COORD_W-1:0] pos_y;
    logic signed [sts_pkg::COORD_W-1:0] pos_z;
    logic signed [sts_pkg::NORM_W-1:0]  face_nx;
    logic signed [sts_pkg::NORM_W-1:0]  face_ny;
    logic signed [sts_pkg::NORM_W-1:0]  face_nz;
    logic                               last_vertex;

    modport source (output valid, pos_x, pos_y, pos_z, face_nx, face_ny, face_nz,
                    last_vertex, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, face_nx, face_ny, face_nz,
                  last_vertex, output ready);
endinterface

`default_nettype wire

FILE: design/sts_proj.sv
// midpoint projection unit: bit-serial square root and three 17-step dividers
// depends on sts_pkg
`default_nettype none

module sts_proj (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire sts_pkg::vec_t             p,
    input  wire sts_pkg::vec_t             q,
    input  wire logic [sts_pkg::RAD_W-1:0] radius,
    output logic                           done,
    output sts_pkg::vec_t                  m
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       done_reg, done_next;

    logic signed [sts_pkg::SUM_W-1:0]  s_reg    [3];
    logic [sts_pkg::SQ_W-1:0]          sq_reg   [3];
    logic [sts_pkg::PROD_W-1:0]        prod_reg [3];
    logic [sts_pkg::RADICAND_W-1:0]    rad_reg;
    logic [sts_pkg::ROOT_W-1:0]        root_reg;
    logic [sts_pkg::ROOT_W+1:0]        rem_reg;
    logic [sts_pkg::ROOT_W-1:0]        drem_reg [3];
    logic [sts_pkg::QUO_W-1:0]         dq_reg   [3];
    logic [sts_pkg::QUO_W-1:0]         quo_reg  [3];
    logic                              big_reg  [3];
    sts_pkg::vec_t                     m_reg;

    logic signed [sts_pkg::COORD_W-1:0] pa [3];
    logic signed [sts_pkg::COORD_W-1:0] qa [3];
    logic [sts_pkg::SUM_W-1:0]          mag   [3];
    logic [2*sts_pkg::SUM_W-1:0]        sqw   [3];
    logic [sts_pkg::L2_W-1:0]           l2;
    logic [sts_pkg::ROOT_W+3:0]         rem_t;
    logic [sts_pkg::ROOT_W+3:0]         trial;
    logic                               root_ge;
    logic [sts_pkg::DIVD_W-1:0]         divd  [3];
    logic                               big_c [3];
    logic [sts_pkg::ROOT_W:0]           r2    [3];
    logic [sts_pkg::ROOT_W:0]           r2_sub[3];
    logic                               div_ge[3];
    logic [sts_pkg::COORD_W+1:0]        neg_q [3];
    sts_pkg::coord_t                    fin_c [3];

    always_comb
    begin
        pa[0] = p.x;
        pa[1] = p.y;
        pa[2] = p.z;
        qa[0] = q.x;
        qa[1] = q.y;
        qa[2] = q.z;
        l2 = sts_pkg::L2_W'(sq_reg[0]) + sts_pkg::L2_W'(sq_reg[1])
           + sts_pkg::L2_W'(sq_reg[2]);
        // restoring square root, two radicand bits per step
        rem_t   = {rem_reg, rad_reg[sts_pkg::RADICAND_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        root_ge = rem_t >= trial;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = s_reg[i][sts_pkg::SUM_W-1] ? sts_pkg::SUM_W'(-s_reg[i])
                                                 : sts_pkg::SUM_W'(s_reg[i]);
            sqw[i] = (2 * sts_pkg::SUM_W)'(mag[i]) * (2 * sts_pkg::SUM_W)'(mag[i]);
            // rounding bias of half the length is folded into the dividend
            divd[i] = {1'b0, prod_reg[i], {sts_pkg::GUARD_W{1'b0}}}
                    + sts_pkg::DIVD_W'(root_reg >> 1);
            big_c[i] = {1'b0, divd[i]} >= {root_reg, {sts_pkg::QUO_W{1'b0}}};
            r2[i] = {drem_reg[i], dq_reg[i][sts_pkg::QUO_W-1]};
            div_ge[i] = r2[i] >= {1'b0, root_reg};
            r2_sub[i] = r2[i] - {1'b0, root_reg};
            neg_q[i] = '0 - (sts_pkg::COORD_W + 2)'(quo_reg[i]);
            if (s_reg[i][sts_pkg::SUM_W-1])
            begin
                if (big_reg[i] || quo_reg[i] > sts_pkg::NEG_LIMIT)
                    fin_c[i] = sts_pkg::COORD_MIN;
                else
                    fin_c[i] = neg_q[i][sts_pkg::COORD_W-1:0];
            end
            else
            begin
                if (big_reg[i] || quo_reg[i] > sts_pkg::POS_LIMIT)
                    fin_c[i] = sts_pkg::COORD_MAX;
                else
                    fin_c[i] = quo_reg[i][sts_pkg::COORD_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = done_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SQ;
                    done_next  = 1'b0;
                end
            end
            S_SQ:
                state_next = S_SUM;
            S_SUM:
            begin
                cnt_next = '0;
                if (l2 == '0)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                    state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(sts_pkg::ROOT_W - 1))
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(sts_pkg::QUO_W - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                        s_reg[i] <= sts_pkg::SUM_W'(pa[i]) + sts_pkg::SUM_W'(qa[i]);
                end
            end
            S_SQ:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i]   <= sqw[i][sts_pkg::SQ_W-1:0];
                    prod_reg[i] <= sts_pkg::PROD_W'(mag[i]) * sts_pkg::PROD_W'(radius);
                end
            end
            S_SUM:
            begin
                rad_reg  <= {l2, {(2 * sts_pkg::GUARD_W){1'b0}}};
                root_reg <= '0;
                rem_reg  <= '0;
                m_reg    <= '0;
            end
            S_ROOT:
            begin
                rad_reg <= rad_reg << 2;
                if (root_ge)
                begin
                    rem_reg  <= (sts_pkg::ROOT_W + 2)'(rem_t - trial);
                    root_reg <= {root_reg[sts_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_t[sts_pkg::ROOT_W+1:0];
                    root_reg <= {root_reg[sts_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            S_CHK:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[i] <= sts_pkg::ROOT_W'(divd[i][sts_pkg::DIVD_W-1:sts_pkg::QUO_W]);
                    dq_reg[i]   <= divd[i][sts_pkg::QUO_W-1:0];
                    big_reg[i]  <= big_c[i];
                end
            end
            S_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[i] <= div_ge[i] ? r2_sub[i][sts_pkg::ROOT_W-1:0]
                                             : r2[i][sts_pkg::ROOT_W-1:0];
                    quo_reg[i]  <= {quo_reg[i][sts_pkg::QUO_W-2:0], div_ge[i]};
                    dq_reg[i]   <= dq_reg[i] << 1;
                end
            end
            S_FIN:
            begin
                m_reg.x <= fin_c[0];
                m_reg.y <= fin_c[1];
                m_reg.z <= fin_c[2];
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign m    = m_reg;

endmodule

`default_nettype wire

FILE: design/sts_front.sv
// front end: takes a triangle transaction and projects its three midpoints
// depends on sts_pkg, sts_intf and sts_proj
`default_nettype none

module sts_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    sts_tri_if.sink                        tri_in,
    input  wire logic [sts_pkg::RAD_W-1:0] radius,
    input  wire logic                      full,
    output logic                           push,
    output sts_pkg::job_t                  job
);

    logic          hold_valid_reg;
    logic          run_reg;
    sts_pkg::vec_t hold_reg [3];
    sts_pkg::vec_t work_reg [3];
    logic          accept;
    logic          start;
    logic          done01, done12, done20;
    sts_pkg::vec_t m01, m12, m20;

    assign tri_in.ready = !hold_valid_reg;
    assign accept       = tri_in.valid && tri_in.ready;
    assign start        = hold_valid_reg && !run_reg;
    assign push         = run_reg && done01 && done12 && done20 && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            run_reg        <= 1'b0;
        end
        else
        begin
            if (accept)
                hold_valid_reg <= 1'b1;
            else if (start)
                hold_valid_reg <= 1'b0;
            if (start)
                run_reg <= 1'b1;
            else if (push)
                run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg[0] <= '{x: tri_in.a_x, y: tri_in.a_y, z: tri_in.a_z};
            hold_reg[1] <= '{x: tri_in.b_x, y: tri_in.b_y, z: tri_in.b_z};
            hold_reg[2] <= '{x: tri_in.c_x, y: tri_in.c_y, z: tri_in.c_z};
        end
        if (start)
        begin
            for (int i = 0; i < 3; i++)
                work_reg[i] <= hold_reg[i];
        end
    end

    sts_proj u_proj01 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .p      (hold_reg[0]),
        .q      (hold_reg[1]),
        .radius (radius),
        .done   (done01),
        .m      (m01)
    );

    sts_proj u_proj12 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .p      (hold_reg[1]),
        .q      (hold_reg[2]),
        .radius (radius),
        .done   (done12),
        .m      (m12)
    );

    sts_proj u_proj20 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .p      (hold_reg[2]),
        .q      (hold_reg[0]),
        .radius (radius),
        .done   (done20),
        .m      (m20)
    );

    always_comb
    begin
        job.v0  = work_reg[0];
        job.v1  = work_reg[1];
        job.v2  = work_reg[2];
        job.m01 = m01;
        job.m12 = m12;
        job.m20 = m20;
    end

endmodule

`default_nettype wire

FILE: design/sts_fifo.sv
// two-entry queue of projected triangles between front and back end
// depends on sts_pkg
`default_nettype none

module sts_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sts_pkg::job_t din,
    input  wire logic          pop,
    output sts_pkg::job_t      dout,
    output logic               full,
    output logic               empty,
    output logic [1:0]         level
);

    sts_pkg::job_t slot_reg [sts_pkg::QDEPTH];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    level_reg;

    assign full  = level_reg == 2'(sts_pkg::QDEPTH);
    assign empty = level_reg == 2'd0;
    assign level = level_reg;
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            level_reg <= level_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

endmodule

`default_nettype wire

FILE: design/sts_back.sv
// back end: face normal per sub-triangle and twelve-vertex emission
// depends on sts_pkg and sts_intf
`default_nettype none

module sts_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sts_pkg::job_t job,
    input  wire logic          empty,
    output logic               pop,
    sts_vtx_if.source          vtx_out
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_SUB  = 2'd2;
    localparam logic [1:0] B_EMIT = 2'd3;

    localparam logic [1:0] LAST_TRI  = 2'd3;
    localparam logic [1:0] LAST_CORN = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [1:0]    tri_reg;
    logic [1:0]    corn_reg;
    logic          out_valid_reg;
    sts_pkg::job_t job_reg;
    sts_pkg::nvec_t norm_reg;
    logic signed [sts_pkg::CROSS_W-1:0] pr_reg [6];

    sts_pkg::vec_t tp, tq, tr, vsel;
    logic signed [sts_pkg::DIFF_W-1:0] e [3];
    logic signed [sts_pkg::DIFF_W-1:0] f [3];
    logic signed [sts_pkg::CROSS_W:0]  dn [3];
    sts_pkg::norm_t                    nsat [3];
    logic load;

    assign pop  = (state_reg == B_IDLE) && !empty;
    assign load = (state_reg == B_EMIT) && (!out_valid_reg || vtx_out.ready);

    always_comb
    begin
        case (tri_reg)
            2'd0:
            begin
                tp = job_reg.v0;
                tq = job_reg.m01;
                tr = job_reg.m20;
            end
            2'd1:
            begin
                tp = job_reg.m01;
                tq = job_reg.v1;
                tr = job_reg.m12;
            end
            2'd2:
            begin
                tp = job_reg.m20;
                tq = job_reg.m12;
                tr = job_reg.v2;
            end
            default:
            begin
                tp = job_reg.m01;
                tq = job_reg.m12;
                tr = job_reg.m20;
            end
        endcase
        case (corn_reg)
            2'd1:    vsel = tq;
            2'd2:    vsel = tr;
            default: vsel = tp;
        endcase
        e[0] = sts_pkg::DIFF_W'(tq.x) - sts_pkg::DIFF_W'(tp.x);
        e[1] = sts_pkg::DIFF_W'(tq.y) - sts_pkg::DIFF_W'(tp.y);
        e[2] = sts_pkg::DIFF_W'(tq.z) - sts_pkg::DIFF_W'(tp.z);
        f[0] = sts_pkg::DIFF_W'(tr.x) - sts_pkg::DIFF_W'(tp.x);
        f[1] = sts_pkg::DIFF_W'(tr.y) - sts_pkg::DIFF_W'(tp.y);
        f[2] = sts_pkg::DIFF_W'(tr.z) - sts_pkg::DIFF_W'(tp.z);
        for (int i = 0; i < 3; i++)
        begin
            dn[i] = (sts_pkg::CROSS_W + 1)'(pr_reg[2*i])
                  - (sts_pkg::CROSS_W + 1)'(pr_reg[2*i+1]);
            if (dn[i][sts_pkg::CROSS_W] != dn[i][sts_pkg::CROSS_W-1])
                nsat[i] = dn[i][sts_pkg::CROSS_W] ? sts_pkg::NORM_MIN : sts_pkg::NORM_MAX;
            else
                nsat[i] = dn[i][sts_pkg::NORM_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!empty)
                    state_next = B_MUL;
            B_MUL:
                state_next = B_SUB;
            B_SUB:
                state_next = B_EMIT;
            B_EMIT:
            begin
                if (load && corn_reg == LAST_CORN)
                    state_next = (tri_reg == LAST_TRI) ? B_IDLE : B_MUL;
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            tri_reg       <= '0;
            corn_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                tri_reg <= '0;
            else if (load && corn_reg == LAST_CORN)
                tri_reg <= tri_reg + 2'd1;
            if (state_reg == B_SUB)
                corn_reg <= '0;
            else if (load)
                corn_reg <= corn_reg + 2'd1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (vtx_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= job;
        if (state_reg == B_MUL)
        begin
            pr_reg[0] <= sts_pkg::CROSS_W'(e[1]) * sts_pkg::CROSS_W'(f[2]);
            pr_reg[1] <= sts_pkg::CROSS_W'(e[2]) * sts_pkg::CROSS_W'(f[1]);
            pr_reg[2] <= sts_pkg::CROSS_W'(e[2]) * sts_pkg::CROSS_W'(f[0]);
            pr_reg[3] <= sts_pkg::CROSS_W'(e[0]) * sts_pkg::CROSS_W'(f[2]);
            pr_reg[4] <= sts_pkg::CROSS_W'(e[0]) * sts_pkg::CROSS_W'(f[1]);
            pr_reg[5] <= sts_pkg::CROSS_W'(e[1]) * sts_pkg::CROSS_W'(f[0]);
        end
        if (state_reg == B_SUB)
        begin
            norm_reg.x <= nsat[0];
            norm_reg.y <= nsat[1];
            norm_reg.z <= nsat[2];
        end
        if (load)
        begin
            vtx_out.pos_x       <= vsel.x;
            vtx_out.pos_y       <= vsel.y;
            vtx_out.pos_z       <= vsel.z;
            vtx_out.face_nx     <= norm_reg.x;
            vtx_out.face_ny     <= norm_reg.y;
            vtx_out.face_nz     <= norm_reg.z;
            vtx_out.last_vertex <= (tri_reg == LAST_TRI) && (corn_reg == LAST_CORN);
        end
    end

    assign vtx_out.valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: design/sphere_triangle_subdivider.sv
// the front end accepts the next triangle while the last one is being projected;
// triangles are paced by the 29-step square root and 17-step divide in each of
// the three midpoint projection units; the back end emits the twelve vertices,
// one per cycle once a normal is ready and while the vertex sink is ready
// reset: clears all control state and loads the radius with 1.0; no clearing pass
`default_nettype none

module sphere_triangle_subdivider (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [sts_pkg::RAD_W-1:0] cfg_wr_data,
    sts_tri_if.sink                        tri_in,
    sts_vtx_if.source                      vtx_out
);

    logic [sts_pkg::RAD_W-1:0] radius_reg;
    sts_pkg::job_t             job_in;
    sts_pkg::job_t             job_out;
    logic                      job_push;
    logic                      job_pop;
    logic                      fifo_full;
    logic                      fifo_empty;
    logic [1:0]                fifo_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= sts_pkg::RADIUS_RESET;
        else if (cfg_wr_en)
            radius_reg <= cfg_wr_data;
    end

    sts_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .tri_in (tri_in),
        .radius (radius_reg),
        .full   (fifo_full),
        .push   (job_push),
        .job    (job_in)
    );

    sts_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .pop   (job_pop),
        .dout  (job_out),
        .full  (fifo_full),
        .empty (fifo_empty),
        .level (fifo_level)
    );

    sts_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (job_out),
        .empty   (fifo_empty),
        .pop     (job_pop),
        .vtx_out (vtx_out)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (fifo_level != 2'(sts_pkg::QDEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (fifo_level != 2'd0))
        else $error("queue read while empty");

    a_level_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (fifo_level == $past(fifo_level) + 2'($past(job_push))
                                - 2'($past(job_pop))))
        else $error("queue level does not follow push and pop");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// testbench for the sphere triangle subdivider: random and directed triangles,
// vertices checked against an in-bench predictor; depends on sts_pkg, sts_intf and sphere_triangle_subdivider
`default_nettype none

module tb_top;

    typedef struct {
        logic signed [15:0] c [9];
    } tri_t;

    typedef struct {
        logic signed [15:0] px, py, pz;
        logic signed [33:0] nx, ny, nz;
        logic               last;
    } vtx_t;

    typedef struct {
        logic       is_cfg;
        logic [14:0] radius;
        tri_t       tri_data;
    } job_entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [sts_pkg::RAD_W-1:0] cfg_wr_data = '0;
    logic tri_taken = 1'b0;

    sts_tri_if tri_ch();
    sts_vtx_if vtx_ch();

    sphere_triangle_subdivider dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .tri_in(tri_ch.sink), .vtx_out(vtx_ch.source)
    );

    always #10 clk = ~clk;

    job_entry_t pending_jobs [$];
    vtx_t       expected_vertices [$];
    logic [14:0] radius_model = 15'd4096;
    int errors = 0;
    int vertices_seen = 0;
    int triangles_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    longint cycle_count = 0;

    function automatic longint sat_to(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint root_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic midpoint_on_sphere(input longint p [3], input longint q [3],
                                      output longint m [3]);
        longint s [3];
        longint unsigned l2, len, mag, num, v;
        l2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            s[i] = p[i] + q[i];
            l2 += s[i] * s[i];
        end
        if (l2 == 0)
        begin
            for (int i = 0; i < 3; i++) m[i] = 0;
            return;
        end
        len = root_floor(l2 << 24);
        for (int i = 0; i < 3; i++)
        begin
            mag = s[i] < 0 ? -s[i] : s[i];
            num = (mag * radius_model) << 12;
            v = (num + len / 2) / len;
            m[i] = sat_to(s[i] < 0 ? -longint'(v) : longint'(v), 16);
        end
    endtask

    task automatic predict_vertices(input tri_t t);
        longint pt [6][3];
        longint e [3], f [3], n [3];
        int order [12] = '{0, 3, 5, 3, 1, 4, 5, 4, 2, 3, 4, 5};
        vtx_t o;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) pt[i][k] = longint'(t.c[i * 3 + k]);
        midpoint_on_sphere(pt[0], pt[1], pt[3]);
        midpoint_on_sphere(pt[1], pt[2], pt[4]);
        midpoint_on_sphere(pt[2], pt[0], pt[5]);
        for (int tr = 0; tr < 4; tr++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e[k] = pt[order[tr * 3 + 1]][k] - pt[order[tr * 3]][k];
                f[k] = pt[order[tr * 3 + 2]][k] - pt[order[tr * 3]][k];
            end
            n[0] = sat_to(e[1] * f[2] - e[2] * f[1], 34);
            n[1] = sat_to(e[2] * f[0] - e[0] * f[2], 34);
            n[2] = sat_to(e[0] * f[1] - e[1] * f[0], 34);
            for (int i = 0; i < 3; i++)
            begin
                o.px = 16'(pt[order[tr * 3 + i]][0]);
                o.py = 16'(pt[order[tr * 3 + i]][1]);
                o.pz = 16'(pt[order[tr * 3 + i]][2]);
                o.nx = 34'(n[0]);
                o.ny = 34'(n[1]);
                o.nz = 34'(n[2]);
                o.last = (tr == 3 && i == 2);
                expected_vertices.insert(expected_vertices.size(), o);
            end
        end
    endtask

    // input transaction taken at this rising edge
    always @(posedge clk)
        tri_taken <= rst_n && tri_ch.valid && tri_ch.ready;

    // driver: one queue entry at a time; a config entry at the head holds the triangle channel idle
    always @(negedge clk)
    begin
        job_entry_t taken;
        if (rst_n)
        begin
            if (tri_taken)
            begin
                taken = pending_jobs.pop_front();
                predict_vertices(taken.tri_data);
                triangles_sent++;
            end
            if (!tri_ch.valid || tri_taken)
            begin
                if (pending_jobs.size() > 0 && pending_jobs[0].is_cfg)
                begin
                    tri_ch.valid <= 1'b0;
                end
                else if (pending_jobs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    tri_ch.valid <= 1'b1;
                    {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z} <=
                        {pending_jobs[0].tri_data.c[0], pending_jobs[0].tri_data.c[1],
                         pending_jobs[0].tri_data.c[2]};
                    {tri_ch.b_x, tri_ch.b_y, tri_ch.b_z} <=
                        {pending_jobs[0].tri_data.c[3], pending_jobs[0].tri_data.c[4],
                         pending_jobs[0].tri_data.c[5]};
                    {tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} <=
                        {pending_jobs[0].tri_data.c[6], pending_jobs[0].tri_data.c[7],
                         pending_jobs[0].tri_data.c[8]};
                end
                else
                    tri_ch.valid <= 1'b0;
            end
            vtx_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        vtx_t want;
        cycle_count++;
        if (rst_n && vtx_ch.valid && vtx_ch.ready)
        begin
            vertices_seen++;
            if (expected_vertices.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected vertex %0d %0d %0d", $time,
                         vtx_ch.pos_x, vtx_ch.pos_y, vtx_ch.pos_z);
            end
            else
            begin
                want = expected_vertices.pop_front();
                if ({vtx_ch.pos_x, vtx_ch.pos_y, vtx_ch.pos_z, vtx_ch.face_nx,
                     vtx_ch.face_ny, vtx_ch.face_nz, vtx_ch.last_vertex} !==
                    {want.px, want.py, want.pz, want.nx, want.ny, want.nz, want.last})
                begin
                    errors++;
                    $display("%0t: expected pos %0d %0d %0d n %0d %0d %0d last %0b",
                             $time, want.px, want.py, want.pz, want.nx, want.ny,
                             want.nz, want.last);
                    $display("%0t: actual   pos %0d %0d %0d n %0d %0d %0d last %0b",
                             $time, vtx_ch.pos_x, vtx_ch.pos_y, vtx_ch.pos_z,
                             vtx_ch.face_nx, vtx_ch.face_ny, vtx_ch.face_nz,
                             vtx_ch.last_vertex);
                end
            end
        end
        if (cycle_count > 2000000)
        begin
            $display("%0t: timeout", $time);
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic tri_t random_triangle(int mode);
        tri_t t;
        for (int i = 0; i < 9; i++)
        begin
            case (mode)
                0: t.c[i] = 16'($urandom);
                1: t.c[i] = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
                default: t.c[i] = ($urandom_range(1)) ? 16'sh7fff : -16'sh8000;
            endcase
        end
        return t;
    endfunction

    task automatic queue_triangle(input tri_t t);
        job_entry_t j;
        j.is_cfg = 1'b0;
        j.radius = '0;
        j.tri_data = t;
        pending_jobs.insert(pending_jobs.size(), j);
    endtask

    task automatic wait_drained();
        while (pending_jobs.size() > 0 || expected_vertices.size() > 0 || tri_ch.valid)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_radius(input logic [14:0] r);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= r;
        radius_model = r;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        tri_t t;
        logic [14:0] radii [5];
        int idle_mode [4][2];
        radii = '{15'd4096, 15'd32767, 15'd0, 15'd1, 15'd12000};
        idle_mode = '{'{0, 0}, '{85, 0}, '{0, 85}, '{18, 18}};
        tri_ch.valid = 1'b0;
        {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z, tri_ch.b_x, tri_ch.b_y, tri_ch.b_z,
         tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} = '0;
        vtx_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero midpoints, extremes, opposite vertices, unit axes
        for (int i = 0; i < 9; i++) t.c[i] = 0;
        queue_triangle(t);
        for (int i = 0; i < 9; i++) t.c[i] = 16'sh7fff;
        queue_triangle(t);
        for (int i = 0; i < 9; i++) t.c[i] = -16'sh8000;
        queue_triangle(t);
        for (int i = 0; i < 9; i++) t.c[i] = (i % 2) ? -16'sh8000 : 16'sh7fff;
        queue_triangle(t);
        t.c = '{16'sd4096, 0, 0, 0, 16'sd4096, 0, 0, 0, 16'sd4096};
        queue_triangle(t);
        t.c = '{16'sd100, 16'sd5, -16'sd7, -16'sd100, -16'sd5, 16'sd7, 16'sd1, 0, 0};
        queue_triangle(t);
        t.c = '{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff,
                -16'sh8000, 0, 16'sh7fff, -16'sh8000};
        queue_triangle(t);
        wait_drained();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_radius(radii[ph]);
            send_idle_pct = idle_mode[ph % 4][0];
            recv_stall_pct = idle_mode[ph % 4][1];
            for (int n = 0; n < 53; n++)
                queue_triangle(random_triangle((n % 10 == 9) ? 2 : $urandom_range(1)));
            wait_drained();
        end

        $display("covered %0d triangles, %0d vertices, five radius settings",
                 triangles_sent, vertices_seen);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

`default_nettype wire
